/* hw/rtl/lsms_pkg.sv */
// Shared types and constants for the LED and switch matrix scanner.
// No dependencies; every module of the block imports this package.
package lsms_pkg;

  localparam int MaxRows    = 6;
  localparam int MaxColumns = 6;
  localparam int MaxColors  = 3;

  localparam int RowW     = 3;
  localparam int ColW     = 3;
  localparam int ColorW   = 2;
  localparam int TickW    = 16;
  localparam int SenseW   = 6;
  localparam int SinkW    = 18;
  localparam int SwitchW  = MaxColumns * MaxRows;
  localparam int FrameRowW = MaxColumns * MaxColors;
  localparam int SlotW    = 5;

  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    FuncWrite = 2'd0,
    FuncFill  = 2'd1,
    FuncTick  = 2'd2,
    FuncNop   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RegRows    = 3'd0,
    RegColumns = 3'd1,
    RegColors  = 3'd2,
    RegSweep   = 3'd3,
    RegGap     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [RowW-1:0]   led_row;
    logic [ColW-1:0]   led_column;
    logic [ColorW-1:0] led_color;
    logic              bit_value;
    logic [SenseW-1:0] sense_lines;
  } in_item_t;

  typedef struct packed {
    logic [MaxColumns-1:0] column_drive;
    logic [SinkW-1:0]      row_color_sink;
    logic [SenseW-1:0]     sense_drive;
    logic [SwitchW-1:0]    switch_state;
    logic                  in_gap;
  } out_item_t;

  // Effective (clamped) configuration seen by the datapath.
  typedef struct packed {
    logic [RowW-1:0]   nr;
    logic [ColW-1:0]   nc;
    logic [ColorW-1:0] nl;
    logic [TickW-1:0]  sweep_limit;
    logic [TickW-1:0]  gap_ticks;
  } cfg_t;

  // Scan position after the current item, handed to the frame store.
  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColorW-1:0] color;
  } scan_pos_t;

endpackage

/* hw/rtl/lsms_cfg.sv */
// Configuration registers behind the APB-style port, plus clamping.
// Depends on lsms_pkg.
module lsms_cfg import lsms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output logic             pready_o,
  output cfg_t             cfg_o
);

  logic [RowW-1:0]   rows_q;
  logic [ColW-1:0]   cols_q;
  logic [ColorW-1:0] colors_q;
  logic [TickW-1:0]  sweep_q;
  logic [TickW-1:0]  gap_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready_o = 1'b1;
  assign idx      = reg_idx_e'(paddr_i[AddrW-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= RowW'(MaxRows);
      cols_q   <= ColW'(MaxColumns);
      colors_q <= ColorW'(MaxColors);
      sweep_q  <= TickW'(1);
      gap_q    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        RegRows:    rows_q   <= pwdata_i[RowW-1:0];
        RegColumns: cols_q   <= pwdata_i[ColW-1:0];
        RegColors:  colors_q <= pwdata_i[ColorW-1:0];
        RegSweep:   sweep_q  <= pwdata_i[TickW-1:0];
        RegGap:     gap_q    <= pwdata_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegRows:    prdata_o = DataW'(rows_q);
      RegColumns: prdata_o = DataW'(cols_q);
      RegColors:  prdata_o = DataW'(colors_q);
      RegSweep:   prdata_o = DataW'(sweep_q);
      RegGap:     prdata_o = DataW'(gap_q);
      default:    prdata_o = '0;
    endcase
  end

  // Zero counts act as one, counts above the store size act as the maximum.
  always_comb begin
    cfg_o.nr = (rows_q == '0) ? RowW'(1) :
               (rows_q > RowW'(MaxRows)) ? RowW'(MaxRows) : rows_q;
    cfg_o.nc = (cols_q == '0) ? ColW'(1) :
               (cols_q > ColW'(MaxColumns)) ? ColW'(MaxColumns) : cols_q;
    cfg_o.nl = (colors_q == '0) ? ColorW'(1) :
               (colors_q > ColorW'(MaxColors)) ? ColorW'(MaxColors) : colors_q;
    cfg_o.sweep_limit = (sweep_q == '0) ? TickW'(1) : sweep_q;
    cfg_o.gap_ticks   = gap_q;
  end

endmodule

/* hw/rtl/lsms_scan.sv */
// Scan sequencer: slot position, dwell and gap timing, switch map capture.
// Depends on lsms_pkg.
module lsms_scan import lsms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  in_item_t           item_i,
  input  cfg_t               cfg_i,
  output scan_pos_t          pos_o,
  output logic [SinkW-1:0]   sink_o,
  output logic [SenseW-1:0]  sense_o,
  output logic [SwitchW-1:0] switch_o,
  output logic               gap_o
);

  logic [RowW-1:0]    row_q, row_d, row_s;
  logic [ColorW-1:0]  color_q, color_d, color_s;
  logic [TickW-1:0]   dwell_q, dwell_d, dwell_s, dwell_inc;
  logic               gap_q, gap_d, gap_s;
  logic [SwitchW-1:0] sw_q, sw_d;
  logic               restart, tick, capture, slot_done;
  logic [SlotW-1:0]   slot;

  // Drop back to the first slot when the configuration shrank under it.
  assign restart = (row_q >= cfg_i.nr) || (color_q >= cfg_i.nl);
  assign row_s   = restart ? '0 : row_q;
  assign color_s = restart ? '0 : color_q;
  assign dwell_s = restart ? '0 : dwell_q;
  assign gap_s   = restart ? 1'b0 : gap_q;

  assign tick      = (item_i.func == FuncTick);
  assign capture   = tick && !gap_s;
  assign dwell_inc = dwell_s + TickW'(1);
  assign slot_done = gap_s ? ((dwell_inc >= cfg_i.gap_ticks) || (dwell_inc == '0))
                           : ((dwell_inc >= cfg_i.sweep_limit) || (dwell_inc == '0));

  always_comb begin
    row_d   = row_s;
    color_d = color_s;
    dwell_d = dwell_s;
    gap_d   = gap_s;
    if (tick) begin
      if (!slot_done) begin
        dwell_d = dwell_inc;
      end else begin
        dwell_d = '0;
        priority if (gap_s) begin
          gap_d   = 1'b0;
          row_d   = '0;
          color_d = '0;
        end else if (({1'b0, color_s} + 3'd1) < {1'b0, cfg_i.nl}) begin
          color_d = color_s + ColorW'(1);
        end else if (({1'b0, row_s} + 4'd1) < {1'b0, cfg_i.nr}) begin
          color_d = '0;
          row_d   = row_s + RowW'(1);
        end else if (cfg_i.gap_ticks != '0) begin
          gap_d = 1'b1;
        end else begin
          row_d   = '0;
          color_d = '0;
        end
      end
    end
  end

  // Store populated sense lines for the current scan row before advancing.
  always_comb begin
    sw_d = sw_q;
    for (int c = 0; c < MaxColumns; c++) begin
      for (int b = 0; b < MaxRows; b++) begin
        if (capture && (ColW'(c) < cfg_i.nc) && (row_s == RowW'(b))) begin
          sw_d[c*MaxRows + b] = item_i.sense_lines[c];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      color_q <= '0;
      dwell_q <= '0;
      gap_q   <= 1'b0;
      sw_q    <= '0;
    end else if (step_i) begin
      row_q   <= row_d;
      color_q <= color_d;
      dwell_q <= dwell_d;
      gap_q   <= gap_d;
      sw_q    <= sw_d;
    end
  end

  assign pos_o.row   = row_d;
  assign pos_o.color = color_d;
  assign slot        = SlotW'(row_d) * SlotW'(MaxColors) + SlotW'(color_d);

  always_comb begin
    sink_o       = '1;
    sink_o[slot] = 1'b0;
  end

  assign sense_o  = gap_d ? '0 : (SenseW'(1) << row_d);
  assign switch_o = sw_d;
  assign gap_o    = gap_d;

endmodule

/* hw/rtl/lsms_frame.sv */
// One-bit LED frame store, row-sliced, with single write and masked fill.
// Depends on lsms_pkg; reads the scan position from lsms_scan.
module lsms_frame import lsms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  in_item_t              item_i,
  input  cfg_t                  cfg_i,
  input  scan_pos_t             pos_i,
  output logic [MaxColumns-1:0] column_drive_o
);

  logic [MaxRows-1:0][FrameRowW-1:0] frame_q, frame_d;
  logic [SlotW-1:0]                  slot;

  always_comb begin
    frame_d = frame_q;
    for (int r = 0; r < MaxRows; r++) begin
      for (int c = 0; c < MaxColumns; c++) begin
        for (int l = 0; l < MaxColors; l++) begin
          if (((item_i.func == FuncWrite) && (item_i.led_row == RowW'(r)) &&
               (item_i.led_column == ColW'(c)) && (item_i.led_color == ColorW'(l))) ||
              ((item_i.func == FuncFill) && (RowW'(r) < cfg_i.nr) &&
               (ColW'(c) < cfg_i.nc) && (ColorW'(l) < cfg_i.nl))) begin
            frame_d[r][c*MaxColors + l] = item_i.bit_value;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (step_i) begin
      frame_q <= frame_d;
    end
  end

  // Transposed read: column line c shows frame row c at the scan slot.
  assign slot = SlotW'(pos_i.row) * SlotW'(MaxColors) + SlotW'(pos_i.color);

  always_comb begin
    for (int c = 0; c < MaxColumns; c++) begin
      column_drive_o[c] = (ColW'(c) < cfg_i.nc) && frame_d[c][slot];
    end
  end

endmodule

/* hw/rtl/led_and_switch_matrix_scanner.sv */
// Top level of the LED and switch matrix scanner: item pipeline and glue.
// Depends on lsms_pkg, lsms_cfg, lsms_scan and lsms_frame.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one item per
//   cycle: write one LED bit, fill the populated frame, or advance one tick.
//   Every item yields exactly one result item on the output channel
//   (out_valid_o / out_ready_i / out_item_o) that shows the column drive,
//   row/colour sinks, sense drive, switch map and gap flag after the item.
//   Pipeline: an accepted item sits in the input register, is applied to the
//   frame and scan state as it leaves, and its result loads the output
//   register, from where it is offered on the output channel.
//   Throughput: one item per cycle while out_ready_i is high; the state
//   update between input and result register is combinational.
//   Stall: when out_ready_i is low the result holds, the input register
//   keeps one more item and in_ready_o drops only once both are full.
//   Reset: frame and switch map clear, the scan starts at row 0, colour 0,
//   outside the gap; registers return to 6 rows, 6 columns, 3 colours,
//   sweep of one tick, no gap. Write the APB registers only while idle.
module led_and_switch_matrix_scanner import lsms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output logic             pready_o
);

  cfg_t      cfg;
  scan_pos_t pos;
  in_item_t  item_q;
  out_item_t out_d, out_q;
  logic      s1_valid_q, out_valid_q;
  logic      step;

  lsms_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  // Apply the held item when the result register is free or being drained.
  assign step       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  lsms_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .pos_o    (pos),
    .sink_o   (out_d.row_color_sink),
    .sense_o  (out_d.sense_drive),
    .switch_o (out_d.switch_state),
    .gap_o    (out_d.in_gap)
  );

  lsms_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (item_q),
    .cfg_i          (cfg),
    .pos_i          (pos),
    .column_drive_o (out_d.column_drive)
  );

  // Result register: load on step, drop valid once the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // A held item is never dropped while the output side stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !step |=> s1_valid_q)
    else $error("held item lost during stall");

  // Every applied item produces a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("applied item produced no result");

  // Exactly one row/colour sink is active in every result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(~out_item_o.row_color_sink) == 1))
    else $error("row/colour sink not one-cold");

  // Sense drive is one-hot outside the gap and off during it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.in_gap ? (out_item_o.sense_drive == '0)
                                       : $onehot(out_item_o.sense_drive)))
    else $error("sense drive inconsistent with gap flag");
`endif

endmodule

/* bench/tb_led_and_switch_matrix_scanner.sv */
// Testbench for the LED and switch matrix scanner: drives write, fill, tick and no-op items,
// predicts every result item from its own copy of the frame and scan state, checks each one.
// Depends on lsms_pkg and the led_and_switch_matrix_scanner RTL.
`timescale 1ns / 1ps

module tb_led_and_switch_matrix_scanner;
  import lsms_pkg::*;

  localparam int FrameDepth = MaxRows * MaxColumns * MaxColors;
  localparam int CycleLimit = 500000;
  localparam int PhaseCount = 9;
  localparam int PhaseItems = 90;
  localparam int MaxIdle    = 40;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // Clock, reset and DUT pins.
  logic             clk     = 1'b0;
  logic             rst_n   = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  out_item_t        out_item;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Register shadow, as last written (raw, before clamping).
  logic [RowW-1:0]   cfg_rows    = 3'd6;
  logic [ColW-1:0]   cfg_columns = 3'd6;
  logic [ColorW-1:0] cfg_colors  = 2'd3;
  logic [TickW-1:0]  cfg_sweep   = 16'd1;
  logic [TickW-1:0]  cfg_gap     = 16'd0;

  // Predicted block state.
  logic [FrameDepth-1:0] led_frame  = '0;
  logic [SwitchW-1:0]    switch_map = '0;
  int                    view_row    = 0;
  int                    view_color  = 0;
  int                    dwell_ticks = 0;
  logic                  gap_active  = 1'b0;

  // Expected result items, oldest first.
  out_item_t pending_views[$];

  int sender_pct  = 0;
  int stall_pct   = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  // Rows, columns, colours, sweep ticks, gap ticks for each random phase.
  // Include the clamp extremes (zero counts, counts above the maximum, zero sweep)
  // and the widest sweep and gap.
  int setting_list [PhaseCount][5] = '{
    '{6, 6, 3, 1, 0},
    '{0, 0, 0, 0, 0},
    '{7, 7, 3, 1, 1},
    '{3, 4, 2, 2, 3},
    '{1, 6, 1, 3, 0},
    '{6, 1, 3, 1, 2},
    '{2, 2, 2, 65535, 65535},
    '{5, 3, 1, 1, 4},
    '{6, 6, 3, 2, 1}
  };

  led_and_switch_matrix_scanner DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .pready_o   (pready)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_led_and_switch_matrix_scanner failed");
      $finish;
    end
  end

  // Receiver side: drop ready at random, at the rate the current idle mode asks.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A count register of 0 acts as 1, above the maximum as the maximum.
  function automatic int clamp_count(int value, int top);
    if (value == 0) return 1;
    return (value > top) ? top : value;
  endfunction

  function automatic int frame_at(int r, int c, int l);
    return (r * MaxColumns + c) * MaxColors + l;
  endfunction

  // Apply one accepted item to the predicted state and return the view the block
  // must report after it.
  function automatic out_item_t next_scan_view(in_item_t it);
    int        nr, nc, nl, limit;
    int        r, c, l;
    out_item_t v;
    nr = clamp_count(int'(cfg_rows), MaxRows);
    nc = clamp_count(int'(cfg_columns), MaxColumns);
    nl = clamp_count(int'(cfg_colors), MaxColors);
    limit = (cfg_sweep == '0) ? 1 : int'(cfg_sweep);

    // A register change can leave the slot outside the populated area:
    // restart the scan from the first slot, outside the gap.
    if (view_row >= nr || view_color >= nl) begin
      view_row    = 0;
      view_color  = 0;
      dwell_ticks = 0;
      gap_active  = 1'b0;
    end

    case (func_e'(it.func))
      FuncWrite: begin
        if (it.led_row < MaxRows && it.led_column < MaxColumns && it.led_color < MaxColors)
          led_frame[frame_at(it.led_row, it.led_column, it.led_color)] = it.bit_value;
      end
      FuncFill: begin
        for (r = 0; r < nr; r++)
          for (c = 0; c < nc; c++)
            for (l = 0; l < nl; l++)
              led_frame[frame_at(r, c, l)] = it.bit_value;
      end
      FuncTick: begin
        if (gap_active) begin
          dwell_ticks = (dwell_ticks + 1) & 16'hFFFF;
          if (dwell_ticks >= int'(cfg_gap) || dwell_ticks == 0) begin
            dwell_ticks = 0;
            gap_active  = 1'b0;
            view_row    = 0;
            view_color  = 0;
          end
        end else begin
          // Capture populated sense lines for the current scan row first.
          for (c = 0; c < nc; c++)
            switch_map[c * MaxRows + view_row] = it.sense_lines[c];
          dwell_ticks = (dwell_ticks + 1) & 16'hFFFF;
          if (dwell_ticks >= limit || dwell_ticks == 0) begin
            dwell_ticks = 0;
            if (view_color + 1 < nl) begin
              view_color++;
            end else if (view_row + 1 < nr) begin
              view_color = 0;
              view_row++;
            end else if (cfg_gap != '0) begin
              gap_active = 1'b1;
            end else begin
              view_row   = 0;
              view_color = 0;
            end
          end
        end
      end
      default: ;
    endcase

    // Column line c of the slot shows frame entry (row c, column scan row, colour).
    v = '0;
    for (c = 0; c < nc; c++)
      if (led_frame[frame_at(c, view_row, view_color)]) v.column_drive[c] = 1'b1;
    v.row_color_sink = '1;
    v.row_color_sink[view_row * MaxColors + view_color] = 1'b0;
    if (!gap_active) v.sense_drive[view_row] = 1'b1;
    v.switch_state = switch_map;
    v.in_gap       = gap_active;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_views.size() == 0) begin
        $display("%0t ns: unexpected result item, expected none, actual %h", $time, out_item);
        mismatches++;
      end else begin
        want = pending_views.pop_front();
        check_field("column_drive",   64'(want.column_drive),   64'(out_item.column_drive));
        check_field("row_color_sink", 64'(want.row_color_sink), 64'(out_item.row_color_sink));
        check_field("sense_drive",    64'(want.sense_drive),    64'(out_item.sense_drive));
        check_field("switch_state",   64'(want.switch_state),   64'(out_item.switch_state));
        check_field("in_gap",         64'(want.in_gap),         64'(out_item.in_gap));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  task automatic set_idle(idle_mode_e mode);
    sender_pct = (mode == IdleSender) ? 78 : (mode == IdleBoth) ? 15 : 0;
    stall_pct  = (mode == IdleReceiver) ? 78 : (mode == IdleBoth) ? 15 : 0;
  endtask

  // Present one item, hold it until accepted, then record its expected view.
  // Valid stays high between back-to-back items; drop it only for an idle gap.
  task automatic send_item(in_item_t it);
    int idle;
    idle = 0;
    while (idle < MaxIdle && $urandom_range(99) < sender_pct) idle++;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    pending_views.push_back(next_scan_view(it));
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(func_e f, int row, int column, int color,
                                         logic value, int sense);
    in_item_t it;
    it.func        = f;
    it.led_row     = RowW'(row);
    it.led_column  = ColW'(column);
    it.led_color   = ColorW'(color);
    it.bit_value   = value;
    it.sense_lines = SenseW'(sense);
    return it;
  endfunction

  // Mostly ticks so the scan moves; writes mostly in range, with some addresses
  // beyond the store; a few fills and no-ops.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    it = make_item(FuncTick, $urandom_range(7), $urandom_range(7), $urandom_range(3),
                   1'($urandom), $urandom_range(63));
    if (pick >= 55 && pick < 85) begin
      it.func = FuncWrite;
      if ($urandom_range(99) < 85) begin
        it.led_row    = RowW'($urandom_range(MaxRows - 1));
        it.led_column = ColW'($urandom_range(MaxColumns - 1));
        it.led_color  = ColorW'($urandom_range(MaxColors - 1));
      end
    end else if (pick >= 85 && pick < 92) begin
      it.func = FuncFill;
    end else if (pick >= 92) begin
      it.func = FuncNop;
    end
    return it;
  endfunction

  // Drop valid and wait until every result item has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup, then access until pready, then idle with psel low.
  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(idx) * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      RegRows:    cfg_rows    = value[RowW-1:0];
      RegColumns: cfg_columns = value[ColW-1:0];
      RegColors:  cfg_colors  = value[ColorW-1:0];
      RegSweep:   cfg_sweep   = value[TickW-1:0];
      RegGap:     cfg_gap     = value[TickW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(int rows, int columns, int colors, int sweep, int gap);
    settle();
    write_reg(RegRows,    DataW'(rows));
    write_reg(RegColumns, DataW'(columns));
    write_reg(RegColors,  DataW'(colors));
    write_reg(RegSweep,   DataW'(sweep));
    write_reg(RegGap,     DataW'(gap));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: field extremes, out-of-range writes, fill, no-op and ticks.
  task automatic test_reset_view();
    set_idle(IdleNone);
    send_item(make_item(FuncNop, 7, 7, 3, 1'b1, 63));
    send_item(make_item(FuncWrite, 0, 0, 0, 1'b1, 0));
    send_item(make_item(FuncWrite, 1, 0, 0, 1'b1, 0));
    send_item(make_item(FuncWrite, 5, 5, 2, 1'b1, 0));
    send_item(make_item(FuncWrite, 7, 7, 3, 1'b1, 0));
    send_item(make_item(FuncWrite, 6, 0, 0, 1'b1, 0));
    send_item(make_item(FuncWrite, 3, 6, 1, 1'b1, 0));
    send_item(make_item(FuncWrite, 3, 0, 3, 1'b1, 0));
    send_item(make_item(FuncFill, 0, 0, 0, 1'b1, 0));
    send_item(make_item(FuncTick, 0, 0, 0, 1'b0, 63));
    send_item(make_item(FuncTick, 0, 0, 0, 1'b0, 0));
    send_item(make_item(FuncTick, 0, 0, 0, 1'b0, 42));
    send_item(make_item(FuncFill, 0, 0, 0, 1'b0, 0));
    send_item(make_item(FuncTick, 0, 0, 0, 1'b0, 21));
  endtask

  // Small sweep with a gap: walk through every slot, into the gap and out again.
  task automatic test_gap_sequence();
    int n;
    apply_setting(2, 3, 2, 2, 3);
    set_idle(IdleBoth);
    send_item(make_item(FuncFill, 0, 0, 0, 1'b1, 0));
    for (n = 0; n < 12; n++)
      send_item(make_item(FuncTick, 0, 0, 0, 1'b0, $urandom_range(63)));
  endtask

  // Shrink the scan area under a running scan so the slot falls outside it.
  task automatic test_slot_restart();
    int n;
    apply_setting(6, 6, 3, 1, 0);
    set_idle(IdleSender);
    for (n = 0; n < 20; n++) send_item(random_item());
    settle();
    write_reg(RegRows, DataW'(2));
    write_reg(RegColors, DataW'(1));
    set_idle(IdleReceiver);
    for (n = 0; n < 20; n++) send_item(random_item());
  endtask

  // Random items across register settings, rotating through the idle modes.
  task automatic test_random_phases();
    int p, n;
    for (p = 0; p < PhaseCount; p++) begin
      apply_setting(setting_list[p][0], setting_list[p][1], setting_list[p][2],
                    setting_list[p][3], setting_list[p][4]);
      set_idle(idle_mode_e'(p % 4));
      for (n = 0; n < PhaseItems; n++) send_item(random_item());
    end
  endtask

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_view();
    test_gap_sequence();
    test_slot_restart();
    test_random_phases();

    // Drain: every result item must be back before the verdict.
    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_led_and_switch_matrix_scanner passed");
    end else begin
      $display("tb_led_and_switch_matrix_scanner failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lsms_pkg.sv
hw/rtl/lsms_cfg.sv
hw/rtl/lsms_scan.sv
hw/rtl/lsms_frame.sv
hw/rtl/led_and_switch_matrix_scanner.sv
bench/tb_led_and_switch_matrix_scanner.sv
